[design/rsfu_pkg.sv]
// ----------------------------------------------------------------------------
// rsfu_pkg
// Shared types, codes and the pixel unpack function of the frame unpacker.
// ----------------------------------------------------------------------------
package rsfu_pkg;

	localparam int MARKER_BYTES = 8;

	// pixel formats
	localparam logic [1:0] FMT_RAW8  = 2'd0;
	localparam logic [1:0] FMT_RAW10 = 2'd1;
	localparam logic [1:0] FMT_RAW16 = 2'd2;
	localparam logic [1:0] FMT_RAW12 = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_PIXEL     = 3'd0;
	localparam logic [2:0] KIND_FRAME_OK  = 3'd1;
	localparam logic [2:0] KIND_FOOT_BAD  = 3'd2;
	localparam logic [2:0] KIND_HEAD_MISS = 3'd3;
	localparam logic [2:0] KIND_TRUNC     = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_PIXEL_FORMAT   = 2'd0;
	localparam logic [1:0] REG_FRAMING_ENABLE = 2'd1;
	localparam logic [1:0] REG_TOTAL_ROWS     = 2'd2;
	localparam logic [1:0] REG_TOTAL_COLS     = 2'd3;

	localparam logic [7:0] MARK_FILL_HEAD = 8'hf0;
	localparam logic [7:0] MARK_FILL_FOOT = 8'hf1;
	localparam logic [7:0] MARK_LAST      = 8'he5;

	// one queue entry: the results caused by one input byte
	typedef struct packed {
		logic [2:0]  kind0;
		logic        two;
		logic [2:0]  kind1;
		logic [1:0]  fmt;
		logic [63:0] raw;
		logic [12:0] row;
		logic [12:0] col;
		logic        fend;
	} rec_t;

	// returns {pixel_d, pixel_c, pixel_b, pixel_a}
	function automatic logic [63:0] unpack_px(input logic [1:0] fmt, input logic [63:0] raw);
		logic [7:0]  b [8];
		logic [63:0] px;
		for (int i = 0; i < 8; i++) begin
			b[i] = raw[8*i +: 8];
		end
		px = '0;
		case (fmt)
			FMT_RAW8: begin
				for (int i = 0; i < 4; i++) begin
					px[16*i +: 16] = {8'h00, b[i]};
				end
			end
			FMT_RAW10: begin
				for (int i = 0; i < 4; i++) begin
					px[16*i +: 16] = {6'b0, b[i], b[4][2*i +: 2]};
				end
			end
			FMT_RAW16: begin
				for (int i = 0; i < 4; i++) begin
					px[16*i +: 16] = {b[2*i+1], b[2*i]};
				end
			end
			default: begin
				px[15:0]  = {4'b0, b[0], b[2][3:0]};
				px[31:16] = {4'b0, b[1], b[2][7:4]};
				px[47:32] = {4'b0, b[3], b[5][3:0]};
				px[63:48] = {4'b0, b[4], b[5][7:4]};
			end
		endcase
		return px;
	endfunction

endpackage

[design/rsfu_queue.sv]
// ----------------------------------------------------------------------------
// rsfu_queue
// Small register queue that decouples the byte parser from the result side.
// ----------------------------------------------------------------------------
module rsfu_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             q_full,
	output logic             q_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign q_full  = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/rsfu_front.sv]
// ----------------------------------------------------------------------------
// rsfu_front
// Byte parser: header search, header skip, pixel group assembly, footer check.
// ----------------------------------------------------------------------------
module rsfu_front import rsfu_pkg::*; #(
	parameter int HEADER_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        q_full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	input  logic [1:0]  pixel_format,
	input  logic        framing_enable,
	input  logic [13:0] total_rows,
	input  logic [13:0] total_cols,
	output logic        q_push,
	output rec_t        q_rec
);

	localparam int SKW = $clog2(HEADER_BYTES);

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_SKIP   = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;
	localparam logic [1:0] PH_FOOTER = 2'd3;

	logic [1:0]     phase_q;
	logic [2:0]     wpos_q;
	logic           wmis_q;
	logic [SKW-1:0] skip_q;
	logic [55:0]    gbytes_q;
	logic [2:0]     gpos_q;
	logic [12:0]    row_q;
	logic [12:0]    col_q;

	logic [1:0]     phase_n;
	logic [2:0]     wpos_n;
	logic           wmis_n;
	logic [SKW-1:0] skip_n;
	logic [55:0]    gbytes_n;
	logic [2:0]     gpos_n;
	logic [12:0]    row_n;
	logic [12:0]    col_n;

	logic        accept;
	logic [13:0] ecols;
	logic [13:0] erows;
	logic [2:0]  glast;
	logic        mism;
	logic [7:0]  mark;
	logic        done;
	logic        have0;
	logic [13:0] col_inc;
	logic [13:0] row_inc;

	assign accept = push && !q_full;

	always_comb begin
		ecols = {total_cols[13:2], 2'b00};
		if (ecols == '0) begin
			ecols = 14'd4;
		end else if (ecols > 14'd8192) begin
			ecols = 14'd8192;
		end
		erows = total_rows;
		if (erows == '0) begin
			erows = 14'd1;
		end else if (erows > 14'd8192) begin
			erows = 14'd8192;
		end
		case (pixel_format)
			FMT_RAW8:  glast = 3'd3;
			FMT_RAW10: glast = 3'd4;
			FMT_RAW16: glast = 3'd7;
			default:   glast = 3'd5;
		endcase
	end

	always_comb begin
		// framing switched off outside the data phase restarts in data
		if (!framing_enable && phase_q != PH_DATA) begin
			phase_n  = PH_DATA;
			wpos_n   = '0;
			wmis_n   = 1'b0;
			skip_n   = '0;
			gbytes_n = '0;
			gpos_n   = '0;
			row_n    = '0;
			col_n    = '0;
		end else begin
			phase_n  = phase_q;
			wpos_n   = wpos_q;
			wmis_n   = wmis_q;
			skip_n   = skip_q;
			gbytes_n = gbytes_q;
			gpos_n   = gpos_q;
			row_n    = row_q;
			col_n    = col_q;
		end

		q_rec       = '0;
		q_rec.fmt   = pixel_format;
		q_rec.row   = row_n;
		q_rec.col   = col_n;
		done        = 1'b0;
		have0       = 1'b0;
		mism        = 1'b0;
		col_inc     = {1'b0, col_n} + 14'd4;
		row_inc     = {1'b0, row_n} + 14'd1;

		if (phase_n == PH_FOOTER) begin
			mark = (wpos_n == 3'd7) ? MARK_LAST : MARK_FILL_FOOT;
		end else begin
			mark = (wpos_n == 3'd7) ? MARK_LAST : MARK_FILL_HEAD;
		end

		for (int k = 0; k < 8; k++) begin
			if (3'(k) == glast) begin
				q_rec.raw[8*k +: 8] = data_byte;
			end else if (k < 7) begin
				q_rec.raw[8*k +: 8] = gbytes_n[8*k +: 8];
			end
		end

		case (phase_n)
			PH_SEARCH: begin
				mism = wmis_n || (data_byte != mark);
				if (wpos_n == 3'd7) begin
					wpos_n = '0;
					wmis_n = 1'b0;
					if (!mism && !end_of_buffer) begin
						gbytes_n = '0;
						gpos_n   = '0;
						row_n    = '0;
						col_n    = '0;
						skip_n   = SKW'(HEADER_BYTES - MARKER_BYTES);
						phase_n  = (HEADER_BYTES > MARKER_BYTES) ? PH_SKIP : PH_DATA;
					end
				end else begin
					wpos_n = wpos_n + 1'b1;
					wmis_n = mism;
				end
			end
			PH_SKIP: begin
				if (skip_n != '0) begin
					skip_n = skip_n - 1'b1;
				end
				if (skip_n == '0) begin
					phase_n  = PH_DATA;
					gbytes_n = '0;
					gpos_n   = '0;
					row_n    = '0;
					col_n    = '0;
				end
			end
			PH_DATA: begin
				if (gpos_n >= glast) begin
					have0       = 1'b1;
					q_rec.kind0 = KIND_PIXEL;
					gbytes_n    = '0;
					gpos_n      = '0;
					if (col_inc >= ecols) begin
						col_n = '0;
						row_n = row_inc[12:0];
						if (row_inc >= erows) begin
							q_rec.fend = 1'b1;
							row_n      = '0;
							if (framing_enable) begin
								phase_n = PH_FOOTER;
								wpos_n  = '0;
								wmis_n  = 1'b0;
							end else begin
								q_rec.two   = 1'b1;
								q_rec.kind1 = KIND_FRAME_OK;
								done        = 1'b1;
							end
						end
					end else begin
						col_n = col_inc[12:0];
					end
				end else begin
					for (int i = 0; i < 7; i++) begin
						if (gpos_n == 3'(i)) begin
							gbytes_n[8*i +: 8] = data_byte;
						end
					end
					gpos_n = gpos_n + 1'b1;
				end
			end
			default: begin
				mism = wmis_n || (data_byte != mark);
				if (wpos_n == 3'd7) begin
					have0       = 1'b1;
					q_rec.kind0 = mism ? KIND_FOOT_BAD : KIND_FRAME_OK;
					done        = 1'b1;
					phase_n     = PH_SEARCH;
					wpos_n      = '0;
					wmis_n      = 1'b0;
				end else begin
					wpos_n = wpos_n + 1'b1;
					wmis_n = mism;
				end
			end
		endcase

		// buffer end: report unless a frame just closed, then restart the header search (the data phase with framing off)
		if (end_of_buffer) begin
			if (!done) begin
				if (have0) begin
					q_rec.two   = 1'b1;
					q_rec.kind1 = KIND_TRUNC;
				end else begin
					have0       = 1'b1;
					q_rec.kind0 = (phase_q == PH_SEARCH && framing_enable) ?
						KIND_HEAD_MISS : KIND_TRUNC;
				end
			end
			phase_n  = framing_enable ? PH_SEARCH : PH_DATA;
			wpos_n   = '0;
			wmis_n   = 1'b0;
			skip_n   = '0;
			gbytes_n = '0;
			gpos_n   = '0;
			row_n    = '0;
			col_n    = '0;
		end

		q_push = accept && have0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			wpos_q   <= '0;
			wmis_q   <= 1'b0;
			skip_q   <= '0;
			gbytes_q <= '0;
			gpos_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			wpos_q   <= wpos_n;
			wmis_q   <= wmis_n;
			skip_q   <= skip_n;
			gbytes_q <= gbytes_n;
			gpos_q   <= gpos_n;
			row_q    <= row_n;
			col_q    <= col_n;
		end
	end

endmodule

[design/rsfu_back.sv]
// ----------------------------------------------------------------------------
// rsfu_back
// Result side: unpacks pixel groups and issues one result per transaction.
// ----------------------------------------------------------------------------
module rsfu_back import rsfu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rec_t        head,
	input  logic        q_empty,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  kind,
	output logic [15:0] pixel_a,
	output logic [15:0] pixel_b,
	output logic [15:0] pixel_c,
	output logic [15:0] pixel_d,
	output logic [12:0] row_index,
	output logic [12:0] col_index,
	output logic        frame_end,
	output logic        last_of_run
);

	logic        valid_q;
	logic        sub_q;
	logic [2:0]  kind_q;
	logic [63:0] px_q;
	logic [12:0] row_q;
	logic [12:0] col_q;
	logic        fend_q;
	logic        last_q;

	logic        load;
	logic        sub_n;
	logic [2:0]  kind_n;
	logic [63:0] px_n;
	logic [12:0] row_n;
	logic [12:0] col_n;
	logic        fend_n;
	logic        last_n;

	assign load = !valid_q || pop;

	always_comb begin
		sub_n  = sub_q;
		kind_n = head.kind0;
		px_n   = '0;
		row_n  = '0;
		col_n  = '0;
		fend_n = 1'b0;
		last_n = 1'b1;
		q_pop  = 1'b0;
		if (sub_q) begin
			// second result of a byte never carries pixels
			kind_n = head.kind1;
			if (load && !q_empty) begin
				q_pop = 1'b1;
				sub_n = 1'b0;
			end
		end else begin
			if (head.kind0 == KIND_PIXEL) begin
				px_n   = unpack_px(head.fmt, head.raw);
				row_n  = head.row;
				col_n  = head.col;
				fend_n = head.fend;
			end
			last_n = !head.two;
			if (load && !q_empty) begin
				q_pop = !head.two;
				sub_n = head.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			kind_q <= kind_n;
			px_q   <= px_n;
			row_q  <= row_n;
			col_q  <= col_n;
			fend_q <= fend_n;
			last_q <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= !q_empty;
			end
			sub_q <= sub_n;
		end
	end

	assign empty       = !valid_q;
	assign kind        = kind_q;
	assign pixel_a     = px_q[15:0];
	assign pixel_b     = px_q[31:16];
	assign pixel_c     = px_q[47:32];
	assign pixel_d     = px_q[63:48];
	assign row_index   = row_q;
	assign col_index   = col_q;
	assign frame_end   = fend_q;
	assign last_of_run = last_q;

endmodule

[design/raw_sensor_frame_unpacker.sv]
// ----------------------------------------------------------------------------
// raw_sensor_frame_unpacker
// Raw sensor byte stream to tagged groups of four pixels, with frame checks.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle while the queue is not full. The parser
// handles each byte in the cycle it is accepted and writes the results it
// causes into a QUEUE_DEPTH-entry queue; the result side issues one result
// per cycle from that queue through an output register while pop is held.
// Most bytes cause no result or one; a byte that closes a frame with framing
// off, or that ends the buffer right after a pixel group, causes two, issued
// one after the other, so the input holds one byte per cycle as long as such
// bytes are spaced out and the queue has room. Configuration writes are
// always accepted and should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module raw_sensor_frame_unpacker import rsfu_pkg::*; #(
	parameter int HEADER_BYTES = 64,
	parameter int QUEUE_DEPTH  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [15:0] pixel_a,
	output logic [15:0] pixel_b,
	output logic [15:0] pixel_c,
	output logic [15:0] pixel_d,
	output logic [12:0] row_index,
	output logic [12:0] col_index,
	output logic        frame_end,
	output logic        last_of_run
);

	logic [1:0]  pixel_format_q;
	logic        framing_enable_q;
	logic [13:0] total_rows_q;
	logic [13:0] total_cols_q;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	rec_t q_wr;
	rec_t q_rd;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q   <= FMT_RAW10;
			framing_enable_q <= 1'b1;
			total_rows_q     <= 14'd1540;
			total_cols_q     <= 14'd2688;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_FORMAT:   pixel_format_q   <= cfg_data[1:0];
				REG_FRAMING_ENABLE: framing_enable_q <= cfg_data[0];
				REG_TOTAL_ROWS:     total_rows_q     <= cfg_data;
				REG_TOTAL_COLS:     total_cols_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	rsfu_front #(
		.HEADER_BYTES(HEADER_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.q_full        (q_full),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.pixel_format  (pixel_format_q),
		.framing_enable(framing_enable_q),
		.total_rows    (total_rows_q),
		.total_cols    (total_cols_q),
		.q_push        (q_push),
		.q_rec         (q_wr)
	);

	rsfu_queue #(
		.WIDTH($bits(rec_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wr),
		.rd_en  (q_pop),
		.rd_data(q_rd),
		.q_full (q_full),
		.q_empty(q_empty)
	);

	rsfu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_rd),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.kind       (kind),
		.pixel_a    (pixel_a),
		.pixel_b    (pixel_b),
		.pixel_c    (pixel_c),
		.pixel_d    (pixel_d),
		.row_index  (row_index),
		.col_index  (col_index),
		.frame_end  (frame_end),
		.last_of_run(last_of_run)
	);

endmodule
